### rtl/rud_pkg.sv
// ----------------------------------------------------------------------------
// Restoring divider package
// Field widths, the payload type and the command group that the controller
// sends to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rud_pkg;

	localparam int FIELD_W = 32;

	typedef logic [FIELD_W-1:0] field_t;

	typedef struct packed {
		logic load;
		logic step;
		logic capture;
	} rud_cmd_t;

endpackage

`default_nettype wire

### rtl/rud_if.sv
// ----------------------------------------------------------------------------
// Restoring divider channels
// Valid/ready channels for the operand beats and the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface rud_in_if import rud_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t dividend;
	field_t divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface rud_out_if import rud_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t quotient;
	field_t remainder;

	modport source (output valid, output quotient, output remainder, input ready);
	modport sink (input valid, input quotient, input remainder, output ready);
endinterface

`default_nettype wire

### rtl/rud_datapath.sv
// ----------------------------------------------------------------------------
// Restoring divider datapath
// Partial remainder, dividend/quotient shift register, divisor and result
// registers; one subtractor decides one quotient bit a cycle under cmd.step.
// ----------------------------------------------------------------------------
`default_nettype none

module rud_datapath import rud_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  wire logic     clk,
	input  wire rud_cmd_t cmd,
	input  wire field_t   dividend,
	input  wire field_t   divisor,
	output field_t        quotient,
	output field_t        remainder
);

	localparam int EXT_W = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;

	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] dq_q;
	logic [WIDTH-1:0] dvs_q;
	field_t           quo_q;
	field_t           rem_q;

	logic [EXT_W-1:0] dvd_ext;
	logic [EXT_W-1:0] dvs_ext;
	logic [EXT_W-1:0] quo_ext;
	logic [EXT_W-1:0] rem_ext;
	logic [WIDTH:0]   shifted;
	logic [WIDTH+1:0] diff;
	logic             fits;
	logic [WIDTH-1:0] acc_nxt;
	logic [WIDTH-1:0] dq_nxt;

	assign dvd_ext = EXT_W'(dividend);
	assign dvs_ext = EXT_W'(divisor);

	// The quotient bits enter at the bottom as the dividend bits leave at the top.
	assign shifted = {acc_q, dq_q[WIDTH-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = ~diff[WIDTH+1];
	assign acc_nxt = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
	assign dq_nxt  = {dq_q[WIDTH-2:0], fits};

	assign quo_ext = EXT_W'(dq_nxt);
	assign rem_ext = EXT_W'(acc_nxt);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
			dq_q  <= dvd_ext[WIDTH-1:0];
			dvs_q <= dvs_ext[WIDTH-1:0];
		end else if (cmd.step) begin
			acc_q <= acc_nxt;
			dq_q  <= dq_nxt;
		end
		if (cmd.capture) begin
			quo_q <= quo_ext[FIELD_W-1:0];
			rem_q <= rem_ext[FIELD_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

### rtl/rud_ctrl.sv
// ----------------------------------------------------------------------------
// Restoring divider controller
// Accepts an operand beat, counts the iterations and hands the result to the
// output register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rud_ctrl import rud_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output rud_cmd_t  cmd
);

	localparam int CNT_W = $clog2(WIDTH);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             last;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_free    = ~out_valid_q | out_ready;
	assign last        = (cnt_q == '0);
	assign cmd.load    = in_valid & in_ready;
	assign cmd.step    = (state_q == ST_RUN) & (~last | out_free);
	assign cmd.capture = (state_q == ST_RUN) & last & out_free;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						cnt_q   <= CNT_W'(WIDTH - 1);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.capture) begin
						state_q <= ST_IDLE;
					end else if (cmd.step) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/restoring_unsigned_divider_unit.sv
// ----------------------------------------------------------------------------
// Restoring unsigned divider
// Divides the low WIDTH bits of the dividend by the low WIDTH bits of the
// divisor and returns the quotient and remainder, each trimmed to 32 bits. The
// operands are loaded first, and the single WIDTH + 2 bit subtractor then
// decides one quotient bit per cycle. The result sits in an output register;
// the operand channel is ready again the cycle after the result is written
// there, so a new division overlaps with a result still waiting. If that
// register is still full at the last iteration, the divider holds until it
// drains. A zero divisor gives an all-ones quotient and returns the dividend
// as the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module restoring_unsigned_divider_unit import rud_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rud_in_if.sink    operands,
	rud_out_if.source results
);

	rud_cmd_t cmd;

	rud_ctrl #(
		.WIDTH (WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	rud_datapath #(
		.WIDTH (WIDTH)
	) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.dividend  (operands.dividend),
		.divisor   (operands.divisor),
		.quotient  (results.quotient),
		.remainder (results.remainder)
	);

`ifndef ASSERT_OFF
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		operands.valid && operands.ready |=> !operands.ready)
		else $error("operand channel ready while a division is running");

	a_result_from_capture: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(cmd.capture))
		else $error("result beat raised without a capture");

	a_load_excludes_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.step && !cmd.capture)
		else $error("operand load overlaps an iteration");
`endif

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Restoring unsigned divider testbench
// Sends operand beats to the divider with random gaps on both channels and
// checks every result beat, in order, against quotients and remainders
// worked out by a bit-serial restoring division of its own. A directed run
// covers the field extremes, zero divisors, small dividends and the cases
// where the shifted partial remainder overflows the operand width. Random
// beats follow, in blocks with and without idling.
// ----------------------------------------------------------------------------
`default_nettype none

class division_ledger #(int WIDTH = 32);

	typedef struct {
		rud_pkg::field_t quotient;
		rud_pkg::field_t remainder;
	} quot_rem_t;

	quot_rem_t   owed[$];
	int unsigned faults;

	function void record_operands(rud_pkg::field_t dividend, rud_pkg::field_t divisor);
		logic [WIDTH:0]   partial;
		logic [WIDTH-1:0] dvd;
		logic [WIDTH-1:0] dvs;
		logic [WIDTH-1:0] quo;
		quot_rem_t        sum;
		partial = '0;
		quo = '0;
		dvd = WIDTH'(dividend);
		dvs = WIDTH'(divisor);
		for (int i = WIDTH - 1; i >= 0; i--) begin
			partial = {partial[WIDTH-1:0], dvd[i]};
			if (partial >= {1'b0, dvs}) begin
				partial = partial - {1'b0, dvs};
				quo[i] = 1'b1;
			end
		end
		sum.quotient = rud_pkg::field_t'(quo);
		sum.remainder = rud_pkg::field_t'(partial[WIDTH-1:0]);
		owed.push_back(sum);
	endfunction

	function void check_result(rud_pkg::field_t quotient, rud_pkg::field_t remainder);
		quot_rem_t want;
		if (owed.size() == 0) begin
			faults++;
			if (faults <= 10)
				$display("result beat with nothing owed: quotient %h remainder %h",
					quotient, remainder);
		end else begin
			want = owed.pop_front();
			if (want.quotient !== quotient || want.remainder !== remainder) begin
				faults++;
				if (faults <= 10)
					$display("mismatch: quotient %h (expected %h), remainder %h (expected %h)",
						quotient, want.quotient, remainder, want.remainder);
			end
		end
	endfunction

	function int owed_count();
		return owed.size();
	endfunction

endclass

module testbench import rud_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDTH       = 32;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int BLOCKS      = 11;
	localparam int BLOCK_BEATS = 50;

	logic clk;
	logic arst_n;

	rud_in_if  operands_ch ();
	rud_out_if results_ch ();

	restoring_unsigned_divider_unit #(.WIDTH(WIDTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_ch),
		.results  (results_ch)
	);

	division_ledger #(WIDTH) ledger;
	bit          calm;
	int unsigned sink_hold;
	int unsigned cycles;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 80);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (operands_ch.valid && operands_ch.ready)
				ledger.record_operands(operands_ch.dividend, operands_ch.divisor);
			if (results_ch.valid && results_ch.ready) begin
				ledger.check_result(results_ch.quotient, results_ch.remainder);
				sink_hold = idle_len();
			end
		end
	end

	always @(negedge clk) begin
		if (sink_hold > 0) begin
			results_ch.ready = 1'b0;
			sink_hold--;
		end else begin
			results_ch.ready = 1'b1;
		end
	end

	task automatic send_operands(input field_t dvd, input field_t dvs);
		int unsigned gap;
		gap = idle_len();
		if (gap > 0) begin
			operands_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operands_ch.valid = 1'b1;
		operands_ch.dividend = dvd;
		operands_ch.divisor = dvs;
		do @(posedge clk); while (!operands_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		operands_ch.valid = 1'b0;
		do @(negedge clk); while (ledger.owed_count() != 0);
	endtask

	task automatic send_random();
		field_t dvd;
		field_t dvs;
		dvd = $urandom;
		if ($urandom_range(0, 3) == 0)
			dvd = dvd >> $urandom_range(1, 31);
		case ($urandom_range(0, 9))
			0:       dvs = $urandom_range(0, 1) ? '0 : field_t'(1);
			1, 2:    dvs = $urandom_range(1, 255);
			3:       dvs = field_t'(1) << $urandom_range(0, 31);
			4:       dvs = dvd + field_t'($urandom_range(0, 4)) - field_t'(2);
			5:       dvs = field_t'($urandom) >> $urandom_range(0, 31);
			default: dvs = $urandom;
		endcase
		send_operands(dvd, dvs);
	endtask

	initial begin
		field_t directed_dvd[$];
		field_t directed_dvs[$];
		ledger = new();
		calm = 1'b0;
		sink_hold = 0;
		cycles = 0;
		arst_n = 1'b0;
		operands_ch.valid = 1'b0;
		operands_ch.dividend = '0;
		operands_ch.divisor = '0;
		results_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_dvd = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h0000_0005, 32'h0000_0007, 32'h0000_0064,
			32'hFFFF_FFFE, 32'h0000_3039, 32'h0000_0001, 32'h7FFF_FFFF,
			32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hC000_0000,
			32'h5555_5555, 32'hAAAA_AAAA};
		directed_dvs = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h0000_0001, 32'h0000_0007, 32'h0000_0007, 32'h0000_0007,
			32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000,
			32'h0001_0000, 32'h0000_0002, 32'h8000_0001, 32'hA000_0001,
			32'hAAAA_AAAA, 32'h5555_5555};
		foreach (directed_dvd[i])
			send_operands(directed_dvd[i], directed_dvs[i]);

		// Hold the operand channel until the directed beats have all come back.
		wait_for_drain();

		for (int blk = 0; blk < BLOCKS; blk++) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0)
				wait_for_drain();
			for (int n = 0; n < BLOCK_BEATS; n++)
				send_random();
		end
		calm = 1'b0;
		operands_ch.valid = 1'b0;

		while (ledger.owed_count() != 0)
			@(posedge clk);
		repeat (WIDTH + 8) @(posedge clk);
		if (ledger.faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
